// ===== rtl/core/wmft_pkg.sv =====
`timescale 1ns / 1ps

package wmft_pkg;

	// Field widths fixed by the interface
	localparam int CMD_W = 2;
	localparam int POS_W = 10;
	localparam int VAL_W = 10;

	localparam int POSITIONS = 1 << POS_W;
	localparam int VALUES    = 1 << VAL_W;

	// A count runs 0..POSITIONS
	localparam int CNT_W = $clog2(POSITIONS + 1);

	// Clear sweep covers the deeper of the two cleared memories
	localparam int CLR_W = (POS_W > VAL_W) ? POS_W : VAL_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Controller -> datapath
	typedef struct packed {
		logic clear;     // clear sweep write
		logic accept;    // request taken: latch fields, store read/write
		logic cnt_rd;    // read occurrence count
		logic calc;      // new count, count write, histogram reads
		logic hist_old;  // histogram old-entry write, max update
		logic fin;       // histogram new-entry write, result registers
	} ctrl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;
	} dp_status_t;

endpackage

// ===== rtl/core/wmft_ctrl.sv =====
`timescale 1ns / 1ps

module wmft_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [wmft_pkg::CMD_W-1:0] command,
	input  wmft_pkg::dp_status_t     status,
	output wmft_pkg::ctrl_cmd_t      ctrl,
	output logic                     busy,
	output logic                     done
);
	import wmft_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CNT_RD,
		ST_CALC,
		ST_HIST_OLD,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   is_window_cmd;

	assign is_window_cmd = (command == CMD_ADD) || (command == CMD_REMOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
			case (state_q)
				ST_CLEAR: begin
					if (status.clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start)
						state_q <= is_window_cmd ? ST_CNT_RD : ST_FIN;
				end
				ST_CNT_RD:   state_q <= ST_CALC;
				ST_CALC:     state_q <= ST_HIST_OLD;
				ST_HIST_OLD: state_q <= ST_FIN;
				ST_FIN:      state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctrl.clear    = (state_q == ST_CLEAR);
		ctrl.accept   = (state_q == ST_IDLE) && start;
		ctrl.cnt_rd   = (state_q == ST_CNT_RD);
		ctrl.calc     = (state_q == ST_CALC);
		ctrl.hist_old = (state_q == ST_HIST_OLD);
		ctrl.fin      = (state_q == ST_FIN);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/core/wmft_dp.sv =====
`timescale 1ns / 1ps

module wmft_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wmft_pkg::ctrl_cmd_t        ctrl,
	input  logic [wmft_pkg::CMD_W-1:0] command,
	input  logic [wmft_pkg::POS_W-1:0] position,
	input  logic [wmft_pkg::VAL_W-1:0] element_value,
	output wmft_pkg::dp_status_t       status,
	output logic [wmft_pkg::CNT_W-1:0] max_frequency,
	output logic [wmft_pkg::CNT_W-1:0] value_count,
	output logic                       error
);
	import wmft_pkg::*;

	// Memories. Histogram entry k (k >= 1) lives at address k-1; entry 0 is never read.
	logic [VAL_W-1:0] store_mem [POSITIONS];
	logic [CNT_W-1:0] cnt_mem   [VALUES];
	logic [CNT_W-1:0] hist_mem  [POSITIONS];

	logic [CLR_W-1:0] clr_addr_q;
	logic [CNT_W-1:0] max_q;

	cmd_t             cmd_q;
	logic [VAL_W-1:0] store_rd_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] cnt_rd_q;
	logic [CNT_W-1:0] old_q;
	logic [CNT_W-1:0] new_q;
	logic [CNT_W-1:0] res_q;
	logic             err_q;
	logic [CNT_W-1:0] hist_a_q;
	logic [CNT_W-1:0] hist_b_q;

	logic [CNT_W-1:0] max_frequency_q;
	logic [CNT_W-1:0] value_count_q;
	logic             error_q;

	logic             is_add;
	logic             window_cmd;
	logic             calc_err;
	logic [CNT_W-1:0] calc_new;

	logic             cnt_we;
	logic [VAL_W-1:0] cnt_wa;
	logic [CNT_W-1:0] cnt_wd;

	logic             hist_we;
	logic [POS_W-1:0] hist_wa;
	logic [CNT_W-1:0] hist_wd;

	function automatic logic [POS_W-1:0] hist_idx(input logic [CNT_W-1:0] k);
		logic [CNT_W-1:0] km1;
		km1 = k - CNT_W'(1);
		return km1[POS_W-1:0];
	endfunction

	assign is_add     = (cmd_q == CMD_ADD);
	assign window_cmd = (cmd_q == CMD_ADD) || (cmd_q == CMD_REMOVE);

	// Count step: add refuses at full count, remove refuses at zero
	always_comb begin
		if (is_add) begin
			calc_err = (cnt_rd_q >= CNT_W'(POSITIONS));
			calc_new = cnt_rd_q + CNT_W'(1);
		end else begin
			calc_err = (cnt_rd_q == '0);
			calc_new = cnt_rd_q - CNT_W'(1);
		end
	end

	// Count memory write port
	always_comb begin
		cnt_we = ctrl.clear || (ctrl.calc && !calc_err);
		cnt_wa = ctrl.clear ? clr_addr_q[VAL_W-1:0] : val_q;
		cnt_wd = ctrl.clear ? '0 : calc_new;
	end

	// Histogram write port: clear, old entry down, new entry up
	always_comb begin
		hist_we = ctrl.clear
			|| (ctrl.hist_old && !err_q && (old_q != '0))
			|| (ctrl.fin && window_cmd && !err_q && (new_q != '0));
		if (ctrl.clear) begin
			hist_wa = clr_addr_q[POS_W-1:0];
			hist_wd = '0;
		end else if (ctrl.hist_old) begin
			hist_wa = hist_idx(old_q);
			hist_wd = hist_a_q - CNT_W'(1);
		end else begin
			hist_wa = hist_idx(new_q);
			hist_wd = hist_b_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept && (command == CMD_LOAD))
			store_mem[position] <= element_value;
		if (ctrl.accept)
			store_rd_q <= store_mem[position];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
		if (ctrl.cnt_rd)
			cnt_rd_q <= cnt_mem[store_rd_q];
	end

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_wa] <= hist_wd;
		if (ctrl.calc) begin
			hist_a_q <= hist_mem[hist_idx(cnt_rd_q)];
			hist_b_q <= hist_mem[hist_idx(calc_new)];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctrl.accept)
			cmd_q <= cmd_t'(command);
		if (ctrl.cnt_rd)
			val_q <= store_rd_q;
		if (ctrl.calc) begin
			old_q <= cnt_rd_q;
			new_q <= calc_new;
			err_q <= calc_err;
			res_q <= calc_err ? cnt_rd_q : calc_new;
		end
		if (ctrl.fin) begin
			max_frequency_q <= max_q;
			value_count_q   <= window_cmd ? res_q : '0;
			error_q         <= window_cmd && err_q;
		end
	end

	// Control state: clear sweep address and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			max_q      <= '0;
		end else begin
			if (ctrl.clear)
				clr_addr_q <= clr_addr_q + CLR_W'(1);
			if (ctrl.hist_old && !err_q) begin
				if (is_add) begin
					if (new_q > max_q)
						max_q <= new_q;
				end else if ((old_q == max_q) && (hist_a_q == CNT_W'(1))) begin
					max_q <= max_q - CNT_W'(1);
				end
			end
		end
	end

	assign status.clr_last = (clr_addr_q == '1);

	assign max_frequency = max_frequency_q;
	assign value_count   = value_count_q;
	assign error         = error_q;

endmodule

// ===== rtl/core/window_max_frequency_tracker_core.sv =====
`timescale 1ns / 1ps

// Window max-frequency tracker.
// Request channel: command, position, element_value; a request is taken on the
// rising edge where start is high and busy is low. Commands: load a value into
// the element store at position, add the value at position to the window, or
// remove it. Result channel: max_frequency, value_count, error, valid for the
// single cycle that done is high. The receiver cannot stall; every request
// gives exactly one result.
// After accept, load and the unused code go to FIN; add and remove pass through
// CNT_RD, CALC, HIST_OLD and FIN. The chain of registered reads store -> count
// -> histogram and the single histogram write port set that order; busy drops
// in the done cycle, so a new request can be taken while the result shows.
// Reset: all control state clears, then a clear sweep zeroes the count and
// histogram memories; busy stays high during the sweep. The
// element store is not cleared: adds/removes must target loaded positions.
// Errors: remove at count zero or add at full count leaves state unchanged.
module window_max_frequency_tracker_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [wmft_pkg::CMD_W-1:0] command,
	input  logic [wmft_pkg::POS_W-1:0] position,
	input  logic [wmft_pkg::VAL_W-1:0] element_value,
	output logic                       done,
	output logic [wmft_pkg::CNT_W-1:0] max_frequency,
	output logic [wmft_pkg::CNT_W-1:0] value_count,
	output logic                       error
);
	import wmft_pkg::*;

	// Command and status between controller and datapath
	ctrl_cmd_t  ctrl;
	dp_status_t status;

	// Sequencer: clear sweep, then one request at a time
	wmft_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (status),
		.ctrl    (ctrl),
		.busy    (busy),
		.done    (done)
	);

	// Store, count and histogram memories plus the running maximum
	wmft_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.command       (command),
		.position      (position),
		.element_value (element_value),
		.status        (status),
		.max_frequency (max_frequency),
		.value_count   (value_count),
		.error         (error)
	);

`ifndef SYNTHESIS
	// Result appears only after the request finished
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// Taken request keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accept");

	// Refused step reports count zero (remove) or full count (add)
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> ((value_count == '0) || (value_count == CNT_W'(POSITIONS))))
		else $error("bad count on error");

	// Touched count never exceeds the maximum
	a_count_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !error) |-> (value_count <= max_frequency))
		else $error("count above maximum");
`endif

endmodule
